/* rtl/sau_pkg.sv */
// sorted alarm queue package: request/result structs, status codes,
// cell control struct and controller states
// no dependencies
package sau_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned TagW = 16;
  localparam int unsigned KindW = 2;
  localparam int unsigned TolW = 8;
  localparam logic [TolW-1:0] TolReset = 8'd2;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_TRIGGER = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    STS_INSERTED  = 3'd0,
    STS_AT_HEAD   = 3'd1,
    STS_FULL      = 3'd2,
    STS_EMPTY     = 3'd3,
    STS_EARLY     = 3'd4,
    STS_FIRED     = 3'd5,
    STS_FIRED_BAD = 3'd6
  } status_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } state_t;

  typedef struct packed {
    logic             op;
    logic [TimeW-1:0] alarm_time;
    logic [TagW-1:0]  alarm_tag;
    logic [KindW-1:0] alarm_kind;
    logic [TimeW-1:0] current_time;
  } in_req_t;

  typedef struct packed {
    status_t          status;
    logic [TimeW-1:0] head_time;
    logic [TagW-1:0]  fired_tag;
    logic [KindW-1:0] fired_kind;
    logic             last;
  } out_res_t;

  typedef struct packed {
    logic [TimeW-1:0] alarm_time;
    logic [TagW-1:0]  alarm_tag;
    logic [KindW-1:0] alarm_kind;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctrl_t;

endpackage

/* rtl/sau_cell.sv */
// one slot of the alarm chain: holds an entry and its valid bit,
// shifts right on insert, left on pop; depends on sau_pkg
module sau_cell
  import sau_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  entry_t     new_entry,
  input  logic       prev_less,
  input  entry_t     left_entry,
  input  logic       left_valid,
  input  entry_t     right_entry,
  input  logic       right_valid,
  output entry_t     entry,
  output logic       valid,
  output logic       less
);

  entry_t entry_r, entry_nxt;
  logic   valid_r, valid_nxt;

  assign less = valid_r && (entry_r.alarm_time < new_entry.alarm_time);

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (ctrl.insert) begin
      valid_nxt = left_valid;
      if (!less) begin
        entry_nxt = prev_less ? new_entry : left_entry;
      end
    end else if (ctrl.pop) begin
      valid_nxt = right_valid;
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign valid = valid_r;

endmodule

/* rtl/sorted_alarm_queue_unit.sv */
// sorted alarm queue top: controller, result register and cell chain
// depends on sau_pkg and sau_cell
//
// A chain of QUEUE_DEPTH cells keeps the alarms sorted by time; a new alarm
// goes ahead of earlier ones with the same time. On an insert request every
// cell compares its time with the new one and the chain shifts right at the
// insertion point in the cycle in which the request is taken. A trigger that
// reports empty or early gives one result; a trigger that fires gives one
// result per fired alarm, since each pop is one left shift of the chain and
// fills the result register once. A new request is taken only in a cycle
// in which the result register is empty or its result is being taken, and
// never during a drain. The tolerance register resets to 2 and is written
// through the cfg port; the user must do so only while idle (not enforced).
module sorted_alarm_queue_unit
  import sau_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_req_t         in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output out_res_t        out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [TolW-1:0] cfg_data
);

  state_t           state_r, state_nxt;
  out_res_t         out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             load_out;
  logic [TolW-1:0]  tol_r;
  logic [TimeW-1:0] thresh_r, thresh_nxt;
  cell_ctrl_t       ctrl;
  entry_t           new_entry;

  entry_t entry_w [QUEUE_DEPTH+1];
  logic   valid_w [QUEUE_DEPTH+1];
  logic   less_w  [QUEUE_DEPTH];

  logic slot_free, acc, full, early, last_now, last_drain;

  assign new_entry = '{alarm_time: in_data.alarm_time, alarm_tag: in_data.alarm_tag,
                       alarm_kind: in_data.alarm_kind};

  assign entry_w[QUEUE_DEPTH] = '0;
  assign valid_w[QUEUE_DEPTH] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_e;
    logic   left_v, prev_l;
    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_v = 1'b1;
      assign prev_l = 1'b1;
    end else begin : g_rest
      assign left_e = entry_w[i-1];
      assign left_v = valid_w[i-1];
      assign prev_l = less_w[i-1];
    end
    sau_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .new_entry   (new_entry),
      .prev_less   (prev_l),
      .left_entry  (left_e),
      .left_valid  (left_v),
      .right_entry (entry_w[i+1]),
      .right_valid (valid_w[i+1]),
      .entry       (entry_w[i]),
      .valid       (valid_w[i]),
      .less        (less_w[i])
    );
  end

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && slot_free;
  assign acc       = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign full      = valid_w[QUEUE_DEPTH-1];
  assign early     = ({1'b0, in_data.current_time} + {{(TimeW+1-TolW){1'b0}}, tol_r})
                     < {1'b0, entry_w[0].alarm_time};
  assign last_now   = !(valid_w[1] && (entry_w[1].alarm_time == entry_w[0].alarm_time));
  assign last_drain = !(valid_w[1] && (entry_w[1].alarm_time == thresh_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc && (in_data.op == OP_TRIGGER) && valid_w[0] && !early && !last_now) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (slot_free && last_drain) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and chain control
  always_comb begin
    ctrl       = '0;
    load_out   = 1'b0;
    out_nxt    = '0;
    thresh_nxt = thresh_r;
    out_nxt.status = STS_INSERTED;
    out_nxt.last   = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          load_out = 1'b1;
          if (in_data.op == OP_INSERT) begin
            if (full) begin
              out_nxt.status = STS_FULL;
            end else begin
              ctrl.insert = 1'b1;
              if (!less_w[0]) begin
                out_nxt.status    = STS_AT_HEAD;
                out_nxt.head_time = in_data.alarm_time;
              end
            end
          end else if (!valid_w[0]) begin
            out_nxt.status = STS_EMPTY;
          end else if (early) begin
            out_nxt.status = STS_EARLY;
          end else begin
            ctrl.pop           = 1'b1;
            thresh_nxt         = entry_w[0].alarm_time;
            out_nxt.status     = entry_w[0].alarm_kind[1] ? STS_FIRED_BAD : STS_FIRED;
            out_nxt.head_time  = entry_w[0].alarm_time;
            out_nxt.fired_tag  = entry_w[0].alarm_tag;
            out_nxt.fired_kind = entry_w[0].alarm_kind;
            out_nxt.last       = last_now;
          end
        end
      end
      ST_DRAIN: begin
        if (slot_free) begin
          load_out           = 1'b1;
          ctrl.pop           = 1'b1;
          out_nxt.status     = entry_w[0].alarm_kind[1] ? STS_FIRED_BAD : STS_FIRED;
          out_nxt.head_time  = entry_w[0].alarm_time;
          out_nxt.fired_tag  = entry_w[0].alarm_tag;
          out_nxt.fired_kind = entry_w[0].alarm_kind;
          out_nxt.last       = last_drain;
        end
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      tol_r       <= TolReset;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        tol_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    thresh_r <= thresh_nxt;
    if (load_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_drain_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (valid_w[0] && (entry_w[0].alarm_time == thresh_r)))
    else $error("drain without a matching head entry");

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    valid_w[1] |-> (valid_w[0] && (entry_w[0].alarm_time <= entry_w[1].alarm_time)))
    else $error("chain head out of order");

  a_insert_head: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_data.op == OP_INSERT) && !full) |=>
      (valid_w[0] && (entry_w[0].alarm_time <= $past(in_data.alarm_time))))
    else $error("insert left head later than new alarm");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> !in_ready)
    else $error("request accepted during drain");
`endif

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// testbench for sorted_alarm_queue_unit: a clocked driver and monitor, with an alarm queue
// predictor that works out the results of each request; depends on sau_pkg and the rtl
module tb
  import sau_pkg::*;
();

  localparam int unsigned QUEUE_DEPTH = 32;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  in_req_t         in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_res_t        out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [TolW-1:0] cfg_data = '0;

  in_req_t         alarm_requests[$];
  out_res_t        awaited_results[$];
  entry_t          model_entries[QUEUE_DEPTH];
  int unsigned     model_count = 0;
  logic [TolW-1:0] model_tol = TolReset;

  int unsigned     requests_queued = 0;
  int unsigned     requests_taken = 0;
  int unsigned     mismatches = 0;
  int unsigned     cycle_count = 0;
  int unsigned     send_idle_pct = 38;
  int unsigned     recv_idle_pct = 75;
  out_res_t        want;

  sorted_alarm_queue_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic apply_alarm_request(input in_req_t req);
    out_res_t         r;
    int unsigned      pos;
    int unsigned      j;
    logic [TimeW-1:0] thresh;
    logic [TimeW:0]   reach;
    r = '0;
    r.last = 1'b1;
    if (req.op == OP_INSERT) begin
      if (model_count >= QUEUE_DEPTH) begin
        r.status = STS_FULL;
        awaited_results.push_back(r);
      end else begin
        pos = 0;
        while (pos < model_count && model_entries[pos].alarm_time < req.alarm_time) pos++;
        for (j = model_count; j > pos; j--) model_entries[j] = model_entries[j-1];
        model_entries[pos].alarm_time = req.alarm_time;
        model_entries[pos].alarm_tag = req.alarm_tag;
        model_entries[pos].alarm_kind = req.alarm_kind;
        model_count++;
        if (pos == 0) begin
          r.status = STS_AT_HEAD;
          r.head_time = req.alarm_time;
        end else begin
          r.status = STS_INSERTED;
        end
        awaited_results.push_back(r);
      end
    end else if (model_count == 0) begin
      r.status = STS_EMPTY;
      awaited_results.push_back(r);
    end else begin
      thresh = model_entries[0].alarm_time;
      reach = {1'b0, req.current_time} + {{(TimeW+1-TolW){1'b0}}, model_tol};
      if (reach < {1'b0, thresh}) begin
        r.status = STS_EARLY;
        awaited_results.push_back(r);
      end else begin
        while (model_count > 0 && model_entries[0].alarm_time <= thresh) begin
          r.status = (model_entries[0].alarm_kind >= 2) ? STS_FIRED_BAD : STS_FIRED;
          r.head_time = model_entries[0].alarm_time;
          r.fired_tag = model_entries[0].alarm_tag;
          r.fired_kind = model_entries[0].alarm_kind;
          for (j = 0; j + 1 < model_count; j++) model_entries[j] = model_entries[j+1];
          model_count--;
          r.last = (model_count == 0 || model_entries[0].alarm_time > thresh);
          awaited_results.push_back(r);
        end
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_alarm_request(in_data);
        requests_taken++;
      end
      if (!in_valid || in_ready) begin
        if (alarm_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= alarm_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status=%0d head=%h tag=%h kind=%0d last=%b",
                     out_data.status, out_data.head_time, out_data.fired_tag,
                     out_data.fired_kind, out_data.last);
        end else begin
          want = awaited_results.pop_front();
          if (out_data.status !== want.status || out_data.head_time !== want.head_time ||
              out_data.fired_tag !== want.fired_tag ||
              out_data.fired_kind !== want.fired_kind || out_data.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected status=%0d head=%h tag=%h kind=%0d last=%b",
                       want.status, want.head_time, want.fired_tag, want.fired_kind,
                       want.last);
              $display("          actual   status=%0d head=%h tag=%h kind=%0d last=%b",
                       out_data.status, out_data.head_time, out_data.fired_tag,
                       out_data.fired_kind, out_data.last);
            end
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic queue_request(input logic op, input logic [TimeW-1:0] at,
                               input logic [TagW-1:0] tag, input logic [KindW-1:0] kind,
                               input logic [TimeW-1:0] now);
    in_req_t req;
    req.op = op;
    req.alarm_time = at;
    req.alarm_tag = tag;
    req.alarm_kind = kind;
    req.current_time = now;
    alarm_requests.push_back(req);
    requests_queued++;
  endtask

  task automatic wait_until_drained;
    @(posedge clk);
    while (requests_taken != requests_queued || awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [TolW-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    model_tol = value;
  endtask

  function automatic logic [TimeW-1:0] pick_base();
    int unsigned sel;
    sel = $urandom_range(7);
    if (sel == 0) return $urandom_range(8);
    if (sel == 1) return 32'hFFFF_FFF0 + $urandom_range(15);
    return $urandom;
  endfunction

  // inserts around one base time, then triggers close to it
  task automatic gen_burst(input int unsigned n_ins, input int unsigned spread,
                           input int unsigned n_trig);
    logic [TimeW-1:0] base;
    int unsigned      i;
    base = pick_base();
    for (i = 0; i < n_ins; i++)
      queue_request(OP_INSERT, base + $urandom_range(spread), 16'($urandom),
                    2'($urandom_range(3)), $urandom);
    for (i = 0; i < n_trig; i++)
      queue_request(OP_TRIGGER, $urandom, 16'($urandom), 2'($urandom_range(3)),
                    base - 4 + $urandom_range(spread + 8));
  endtask

  task automatic gen_random(input int unsigned n_items);
    int unsigned target;
    target = requests_queued + n_items;
    while (requests_queued < target) begin
      if ($urandom_range(9) == 0)
        queue_request(1'($urandom_range(1)), $urandom, 16'($urandom),
                      2'($urandom_range(3)), $urandom);
      else if ($urandom_range(11) == 0)
        gen_burst($urandom_range(30, 36), $urandom_range(7), $urandom_range(1, 3));
      else
        gen_burst($urandom_range(1, 6), $urandom_range(7), $urandom_range(1, 4));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    queue_request(OP_TRIGGER, 32'd0, 16'd0, 2'd0, 32'd0);
    queue_request(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 2'd3, 32'hFFFF_FFFF);
    // tolerance sum must not wrap past the top of the time range
    queue_request(OP_TRIGGER, 32'hFFFF_FFFF, 16'hFFFF, 2'd3, 32'hFFFF_FFFE);
    queue_request(OP_INSERT, 32'd100, 16'd0, 2'd0, 32'd0);
    queue_request(OP_INSERT, 32'd100, 16'd1, 2'd1, 32'd0);
    queue_request(OP_INSERT, 32'd50, 16'd2, 2'd2, 32'd0);
    queue_request(OP_INSERT, 32'd200, 16'd3, 2'd3, 32'd0);
    queue_request(OP_TRIGGER, 32'd0, 16'd0, 2'd0, 32'd47);
    queue_request(OP_TRIGGER, 32'd0, 16'd0, 2'd0, 32'd48);
    queue_request(OP_TRIGGER, 32'd0, 16'd0, 2'd0, 32'd0);
    queue_request(OP_TRIGGER, 32'd0, 16'd0, 2'd0, 32'd200);
    queue_request(OP_TRIGGER, 32'd0, 16'd0, 2'd0, 32'hFFFF_FFFF);
    queue_request(OP_TRIGGER, 32'd0, 16'd0, 2'd0, 32'd0);
    queue_request(OP_INSERT, 32'd0, 16'd0, 2'd0, 32'd0);
    queue_request(OP_TRIGGER, 32'd0, 16'd0, 2'd0, 32'd0);
    wait_until_drained();

    // fill to full with equal times, then one trigger near that time drains all of them unless it is early
    gen_burst(34, 0, 1);
    gen_random(25);
    wait_until_drained();
    gen_random(25);
    wait_until_drained();

    write_tolerance(8'd0);
    gen_random(45);
    wait_until_drained();

    send_idle_pct = 75;
    recv_idle_pct = 38;
    write_tolerance(8'd255);
    gen_random(45);
    wait_until_drained();
    write_tolerance(8'($urandom_range(255)));
    gen_random(40);
    wait_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_tolerance(8'd1);
    gen_random(30);
    wait_until_drained();
    write_tolerance(8'd2);
    gen_random(30);
    wait_until_drained();

    repeat (16) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
